FILE: design/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES core package
// Shared payload types, constants and byte-level GF(2^8) helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;

  localparam int unsigned MaxRoundKeysDefault = 15;

  typedef enum logic [1:0] {
    REQ_LOAD_KEY = 2'd0,
    REQ_ENCRYPT  = 2'd1,
    REQ_DECRYPT  = 2'd2,
    REQ_NONE     = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  key_index;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } aes_req_t;

  typedef struct packed {
    logic [63:0] out_hi;
    logic [63:0] out_lo;
    logic        was_decrypt;
  } aes_rsp_t;

  localparam logic [3:0] RoundCountReset = 4'd10;
  localparam logic [3:0] RoundCountMin   = 4'd10;

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // General GF(2^8) multiply by a small constant.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gf_mul = p;
  endfunction

  // Inverse in GF(2^8) by a^254.
  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] b;
    logic [7:0] p;
    logic [7:0] x;
    logic [7:0] y;
    r = 8'h01;
    b = a;
    for (int e = 0; e < 8; e++) begin
      if (e != 0) begin
        p = 8'h00;
        x = r;
        y = b;
        for (int i = 0; i < 8; i++) begin
          if (y[i]) p = p ^ x;
          x = xtime(x);
        end
        r = p;
      end
      p = 8'h00;
      x = b;
      y = b;
      for (int i = 0; i < 8; i++) begin
        if (y[i]) p = p ^ x;
        x = xtime(x);
      end
      b = p;
    end
    gf_inv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    rotl8 = (v << n) | (v >> (8 - n));
  endfunction

  // Forward S-box entry, folded to a constant table by synthesis.
  function automatic logic [7:0] sbox_fwd(input logic [7:0] x);
    logic [7:0] v;
    v = gf_inv(x);
    sbox_fwd = v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ 8'h63;
  endfunction

  // Inverse S-box entry: inverse affine map, then field inverse.
  function automatic logic [7:0] sbox_inv(input logic [7:0] s);
    logic [7:0] v;
    v = rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05;
    sbox_inv = gf_inv(v);
  endfunction

  localparam logic [3:0] ShiftMap [16] = '{
    4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
    4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11};
  localparam logic [3:0] InvShiftMap [16] = '{
    4'd0, 4'd13, 4'd10, 4'd7, 4'd4, 4'd1, 4'd14, 4'd11,
    4'd8, 4'd5, 4'd2, 4'd15, 4'd12, 4'd9, 4'd6, 4'd3};

endpackage
`default_nettype wire

FILE: design/aes_block_cipher_core.sv
// ----------------------------------------------------------------------------
// AES block cipher core
// Round keys live in a synchronous key memory; one shared round unit
// runs one round per cycle.
// ----------------------------------------------------------------------------
// A cipher beat runs the first key read on acceptance, the initial key add in
// ST_FIRST and then the rounds up to Nr in ST_ROUND before the result strobe.
// The core takes no new request while busy, and busy drops as the result strobe
// rises. A key load is written on acceptance and leaves the core idle.
// Reset clears control and round_count (10); the key memory is undefined
// until loaded. The receiver cannot stall: each result shows for one cycle.
`default_nettype none
module aes_block_cipher_core #(
  parameter int unsigned MaxRoundKeys = aes_pkg::MaxRoundKeysDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire aes_pkg::aes_req_t req_i,
  output logic                  done_o,
  output aes_pkg::aes_rsp_t     rsp_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [1:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned IdxW = $clog2(MaxRoundKeys);
  localparam logic [3:0] RoundMax = 4'(MaxRoundKeys - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_ROUND
  } state_e;

  state_e       state_q;
  logic [3:0]   round_count_q;
  logic [3:0]   nr_q;
  logic [3:0]   rnd_q;
  logic         dec_q;
  logic [127:0] data_q;
  logic [127:0] kmem [MaxRoundKeys];
  logic [127:0] key_rd_q;
  logic [IdxW-1:0] rd_addr;
  logic [3:0]   nr_eff;
  logic [127:0] rnd_out;
  logic         last_rnd;
  logic         accept;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = {28'd0, round_count_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= aes_pkg::RoundCountReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      round_count_q <= pwdata[3:0];
    end
  end

  // Clamp the round count to the supported range.
  always_comb begin
    nr_eff = round_count_q;
    if (round_count_q < aes_pkg::RoundCountMin) nr_eff = aes_pkg::RoundCountMin;
    if (round_count_q > RoundMax) nr_eff = RoundMax;
  end

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Key index for the next memory read: first key at start, then the key of
  // the round that follows the one now in the round unit.
  always_comb begin
    logic [3:0] k;
    logic [3:0] nxt;
    nxt = (state_q == ST_ROUND && !last_rnd) ? rnd_q + 4'd1 : rnd_q;
    if (accept) begin
      k = (req_i.req_type == aes_pkg::REQ_DECRYPT) ? nr_eff : 4'd0;
    end else begin
      k = dec_q ? (nr_q - nxt) : nxt;
    end
    rd_addr = k[IdxW-1:0];
  end

  // Key memory: one write port for loads, one registered read port.
  always_ff @(posedge clk_i) begin
    if (accept && req_i.req_type == aes_pkg::REQ_LOAD_KEY
        && {28'd0, req_i.key_index} < MaxRoundKeys) begin
      kmem[req_i.key_index[IdxW-1:0]] <= {req_i.block_hi, req_i.block_lo};
    end
    key_rd_q <= kmem[rd_addr];
  end

  assign last_rnd = (rnd_q == nr_q);

  aes_round u_round (
    .state_i  (data_q),
    .key_i    (key_rd_q),
    .decrypt_i(dec_q),
    .mix_i    (!last_rnd),
    .state_o  (rnd_out)
  );

  // Sequencer with the state register and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_o  <= 1'b0;
      rnd_q   <= 4'd0;
      nr_q    <= 4'd10;
      dec_q   <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (req_i.req_type == aes_pkg::REQ_ENCRYPT
                         || req_i.req_type == aes_pkg::REQ_DECRYPT)) begin
            state_q <= ST_FIRST;
            dec_q   <= (req_i.req_type == aes_pkg::REQ_DECRYPT);
            nr_q    <= nr_eff;
            rnd_q   <= 4'd1;
          end
        end
        ST_FIRST: begin
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          if (last_rnd) begin
            state_q <= ST_IDLE;
            done_o  <= 1'b1;
          end else begin
            rnd_q <= rnd_q + 4'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Working block: load, initial key add, then one round per cycle.
  always_ff @(posedge clk_i) begin
    if (accept) data_q <= {req_i.block_hi, req_i.block_lo};
    else if (state_q == ST_FIRST) data_q <= data_q ^ key_rd_q;
    else if (state_q == ST_ROUND) data_q <= rnd_out;
  end

  assign rsp_o.out_hi      = data_q[127:64];
  assign rsp_o.out_lo      = data_q[63:0];
  assign rsp_o.was_decrypt = dec_q;

endmodule
`default_nettype wire

FILE: design/aes_round.sv
// ----------------------------------------------------------------------------
// AES round unit
// One forward or inverse round on a 128-bit state, byte 0 in the top bits.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_round (
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] key_i,
  input  wire logic         decrypt_i,
  input  wire logic         mix_i,
  output logic [127:0]      state_o
);

  logic [7:0] st [16];
  logic [7:0] ss [16];
  logic [7:0] ak [16];
  logic [7:0] mx [16];

  // Substitute and shift, then key add and mix in the cipher's order.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      st[i] = state_i[127 - 8*i -: 8];
    end
    for (int i = 0; i < 16; i++) begin
      if (decrypt_i) ss[i] = aes_pkg::sbox_inv(st[aes_pkg::InvShiftMap[i]]);
      else           ss[i] = aes_pkg::sbox_fwd(st[aes_pkg::ShiftMap[i]]);
    end
    for (int c = 0; c < 4; c++) begin
      if (decrypt_i) begin
        for (int k = 0; k < 4; k++) ak[4*c+k] = ss[4*c+k] ^ key_i[127 - 8*(4*c+k) -: 8];
        mx[4*c]   = aes_pkg::gf_mul(ak[4*c], 4'd14) ^ aes_pkg::gf_mul(ak[4*c+1], 4'd11)
                  ^ aes_pkg::gf_mul(ak[4*c+2], 4'd13) ^ aes_pkg::gf_mul(ak[4*c+3], 4'd9);
        mx[4*c+1] = aes_pkg::gf_mul(ak[4*c], 4'd9) ^ aes_pkg::gf_mul(ak[4*c+1], 4'd14)
                  ^ aes_pkg::gf_mul(ak[4*c+2], 4'd11) ^ aes_pkg::gf_mul(ak[4*c+3], 4'd13);
        mx[4*c+2] = aes_pkg::gf_mul(ak[4*c], 4'd13) ^ aes_pkg::gf_mul(ak[4*c+1], 4'd9)
                  ^ aes_pkg::gf_mul(ak[4*c+2], 4'd14) ^ aes_pkg::gf_mul(ak[4*c+3], 4'd11);
        mx[4*c+3] = aes_pkg::gf_mul(ak[4*c], 4'd11) ^ aes_pkg::gf_mul(ak[4*c+1], 4'd13)
                  ^ aes_pkg::gf_mul(ak[4*c+2], 4'd9) ^ aes_pkg::gf_mul(ak[4*c+3], 4'd14);
        for (int k = 0; k < 4; k++) begin
          if (!mix_i) mx[4*c+k] = ak[4*c+k];
        end
      end else begin
        mx[4*c]   = aes_pkg::xtime(ss[4*c]) ^ aes_pkg::gf_mul(ss[4*c+1], 4'd3)
                  ^ ss[4*c+2] ^ ss[4*c+3];
        mx[4*c+1] = ss[4*c] ^ aes_pkg::xtime(ss[4*c+1])
                  ^ aes_pkg::gf_mul(ss[4*c+2], 4'd3) ^ ss[4*c+3];
        mx[4*c+2] = ss[4*c] ^ ss[4*c+1] ^ aes_pkg::xtime(ss[4*c+2])
                  ^ aes_pkg::gf_mul(ss[4*c+3], 4'd3);
        mx[4*c+3] = aes_pkg::gf_mul(ss[4*c], 4'd3) ^ ss[4*c+1] ^ ss[4*c+2]
                  ^ aes_pkg::xtime(ss[4*c+3]);
        for (int k = 0; k < 4; k++) begin
          ak[4*c+k] = ss[4*c+k];
          if (!mix_i) mx[4*c+k] = ss[4*c+k];
          mx[4*c+k] = mx[4*c+k] ^ key_i[127 - 8*(4*c+k) -: 8];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      state_o[127 - 8*i -: 8] = mx[i];
    end
  end

endmodule
`default_nettype wire

FILE: bench/aes_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES result checker
// Watches the request, result and register ports of the cipher core. It keeps
// its own round key store and round count, predicts each cipher result when
// its request beat is accepted, and compares every result beat field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module aes_result_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              busy_i,
  input  wire aes_pkg::aes_req_t req_i,
  input  wire logic              done_i,
  input  wire aes_pkg::aes_rsp_t rsp_i,
  input  wire logic              psel_i,
  input  wire logic              penable_i,
  input  wire logic              pwrite_i,
  input  wire logic [1:0]        paddr_i,
  input  wire logic [31:0]       pwdata_i,
  input  wire logic              pready_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     results_o,
  output int                     beats_o
);

  localparam logic [1:0] RegRoundCount = 2'd0;

  logic [7:0]  fwd_sbox [256];
  logic [7:0]  inv_sbox [256];
  logic [63:0] key_words [30];
  logic [3:0]  rounds_cfg;
  aes_pkg::aes_rsp_t expected_q [$];

  // Carry-less multiply reduced by the AES polynomial.
  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
    end
    return p;
  endfunction

  // S-boxes built from the field inverse and the affine map.
  initial begin
    logic [7:0] inv;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gf_times(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sbox[x] = s;
      inv_sbox[s] = 8'(x);
    end
  end

  // Full cipher or inverse cipher of one block with the current key store.
  function automatic aes_pkg::aes_rsp_t cipher_block(input aes_pkg::aes_req_t rq);
    logic [7:0] st [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [3:0] fwd_map [16];
    logic [3:0] rev_map [16];
    int nr;
    int r;
    bit dec;
    aes_pkg::aes_rsp_t res;
    fwd_map = '{0, 5, 10, 15, 4, 9, 14, 3, 8, 13, 2, 7, 12, 1, 6, 11};
    rev_map = '{0, 13, 10, 7, 4, 1, 14, 11, 8, 5, 2, 15, 12, 9, 6, 3};
    dec = (rq.req_type == aes_pkg::REQ_DECRYPT);
    nr = rounds_cfg;
    if (nr < 10) nr = 10;
    if (nr > 14) nr = 14;
    for (int i = 0; i < 8; i++) begin
      st[i]     = rq.block_hi[63 - 8*i -: 8];
      st[8 + i] = rq.block_lo[63 - 8*i -: 8];
    end
    r = dec ? nr : 0;
    for (int step = 0; step <= nr; step++) begin
      // Substitution and row shift, except before the first key addition.
      if (step != 0) begin
        for (int i = 0; i < 16; i++)
          t[i] = dec ? inv_sbox[st[rev_map[i]]] : fwd_sbox[st[fwd_map[i]]];
        st = t;
      end
      // Forward column mix comes before the key addition.
      if (!dec && step != 0 && step != nr) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          st[4*c]   = gf_times(a0, 2) ^ gf_times(a1, 3) ^ a2 ^ a3;
          st[4*c+1] = a0 ^ gf_times(a1, 2) ^ gf_times(a2, 3) ^ a3;
          st[4*c+2] = a0 ^ a1 ^ gf_times(a2, 2) ^ gf_times(a3, 3);
          st[4*c+3] = gf_times(a0, 3) ^ a1 ^ a2 ^ gf_times(a3, 2);
        end
      end
      for (int i = 0; i < 8; i++) begin
        st[i]     ^= key_words[2*r][63 - 8*i -: 8];
        st[8 + i] ^= key_words[2*r + 1][63 - 8*i -: 8];
      end
      // Inverse column mix follows the key addition.
      if (dec && step != 0 && step != nr) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          st[4*c]   = gf_times(a0, 14) ^ gf_times(a1, 11) ^ gf_times(a2, 13) ^ gf_times(a3, 9);
          st[4*c+1] = gf_times(a0, 9) ^ gf_times(a1, 14) ^ gf_times(a2, 11) ^ gf_times(a3, 13);
          st[4*c+2] = gf_times(a0, 13) ^ gf_times(a1, 9) ^ gf_times(a2, 14) ^ gf_times(a3, 11);
          st[4*c+3] = gf_times(a0, 11) ^ gf_times(a1, 13) ^ gf_times(a2, 9) ^ gf_times(a3, 14);
        end
      end
      r = dec ? r - 1 : r + 1;
    end
    for (int i = 0; i < 8; i++) begin
      res.out_hi[63 - 8*i -: 8] = st[i];
      res.out_lo[63 - 8*i -: 8] = st[8 + i];
    end
    res.was_decrypt = dec;
    return res;
  endfunction

  // Result beats are checked first, then request and register beats update state.
  always @(posedge clk_i or negedge rst_ni) begin
    aes_pkg::aes_rsp_t exp_rsp;
    if (!rst_ni) begin
      rounds_cfg = aes_pkg::RoundCountReset;
      expected_q.delete();
      for (int i = 0; i < 30; i++) key_words[i] = '0;
      fail_count_o = 0;
      results_o = 0;
      beats_o = 0;
    end else begin
      if (done_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result beat, expected none, actual %h", $time, rsp_i);
        end else begin
          exp_rsp = expected_q.pop_front();
          if (rsp_i.out_hi !== exp_rsp.out_hi || rsp_i.out_lo !== exp_rsp.out_lo ||
              rsp_i.was_decrypt !== exp_rsp.was_decrypt) begin
            fail_count_o++;
            $display("%0t: result mismatch, expected %h_%h dec=%b, actual %h_%h dec=%b",
                     $time, exp_rsp.out_hi, exp_rsp.out_lo, exp_rsp.was_decrypt,
                     rsp_i.out_hi, rsp_i.out_lo, rsp_i.was_decrypt);
          end
        end
      end
      if (start_i && !busy_i) begin
        beats_o++;
        case (req_i.req_type)
          aes_pkg::REQ_LOAD_KEY: begin
            if (req_i.key_index < 15) begin
              key_words[2*req_i.key_index]     = req_i.block_hi;
              key_words[2*req_i.key_index + 1] = req_i.block_lo;
            end
          end
          aes_pkg::REQ_ENCRYPT, aes_pkg::REQ_DECRYPT:
            expected_q.push_back(cipher_block(req_i));
          default: ;
        endcase
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == RegRoundCount)
        rounds_cfg = pwdata_i[3:0];
    end
  end

  assign pending_o = expected_q.size();

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES block cipher core testbench
// Loads round keys, runs a short directed set and then phases of random
// encrypt, decrypt and key load beats under several round counts, with
// random gaps on the request side. Checking is done by aes_result_checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] RegRoundCount = 2'd0;
  localparam int         StallLimit    = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  aes_pkg::aes_req_t req_i;
  logic        done;
  aes_pkg::aes_rsp_t rsp_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          results;
  int          beats;
  int          quiet_cycles;
  bit          allow_gaps;

  aes_block_cipher_core dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o(done), .rsp_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  aes_result_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .req_i, .done_i(done),
    .rsp_i(rsp_o), .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite),
    .paddr_i(paddr), .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results),
    .beats_o(beats)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on cycles with no request, result or register beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((start && !busy) || done || (psel && penable && pwrite && pready))
        quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("** aes_block_cipher_core: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Presents one request beat and returns once it has been accepted.
  task automatic send_beat(input logic [1:0] kind, input logic [3:0] idx,
                           input logic [63:0] hi, input logic [63:0] lo);
    if (allow_gaps && $urandom_range(99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(20, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{req_type: kind, key_index: idx, block_hi: hi, block_lo: lo};
    do @(posedge clk_i); while (busy);
  endtask

  // Register write while the core is idle.
  task automatic write_rounds(input logic [31:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= RegRoundCount; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random beat: mostly ciphering with some key reloads and unused requests.
  task automatic random_beat();
    int pick;
    logic [63:0] hi;
    logic [63:0] lo;
    pick = $urandom_range(99);
    hi = rand64();
    lo = rand64();
    if ($urandom_range(19) == 0) hi = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(19) == 0) lo = $urandom_range(1) ? '1 : '0;
    if (pick < 12) send_beat(aes_pkg::REQ_LOAD_KEY, 4'($urandom_range(15)), hi, lo);
    else if (pick < 16) send_beat(aes_pkg::REQ_NONE, 4'($urandom), hi, lo);
    else if (pick < 58) send_beat(aes_pkg::REQ_ENCRYPT, 4'($urandom), hi, lo);
    else send_beat(aes_pkg::REQ_DECRYPT, 4'($urandom), hi, lo);
  endtask

  initial begin
    logic [31:0] round_settings [8];
    round_settings = '{12, 14, 11, 13, 0, 15, 9, 10};
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    allow_gaps = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every round key, extremes of the block, ignored requests.
    send_beat(aes_pkg::REQ_LOAD_KEY, 4'd0, '1, '1);
    for (int k = 1; k < 14; k++)
      send_beat(aes_pkg::REQ_LOAD_KEY, 4'(k), rand64(), rand64());
    send_beat(aes_pkg::REQ_LOAD_KEY, 4'd14, '0, '0);
    send_beat(aes_pkg::REQ_LOAD_KEY, 4'd15, rand64(), rand64());
    send_beat(aes_pkg::REQ_ENCRYPT, 4'd0, '0, '0);
    send_beat(aes_pkg::REQ_ENCRYPT, 4'd15, '1, '1);
    send_beat(aes_pkg::REQ_DECRYPT, 4'd0, '0, '0);
    send_beat(aes_pkg::REQ_DECRYPT, 4'd15, '1, '1);
    send_beat(aes_pkg::REQ_NONE, 4'd3, '1, '0);
    send_beat(aes_pkg::REQ_ENCRYPT, 4'd0, 64'h00112233_44556677, 64'h8899aabb_ccddeeff);
    send_beat(aes_pkg::REQ_DECRYPT, 4'd0, 64'h69c4e0d8_6a7b0430, 64'hd8cdb780_70b4c55a);

    // Random phases; the first runs back to back, later ones with gaps.
    for (int ph = 0; ph < 8; ph++) begin
      write_rounds(round_settings[ph]);
      allow_gaps = (ph != 0);
      repeat (128) random_beat();
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Covered %0d request beats and %0d result beats over eight round count settings.",
             beats, results);
    if (fail_count == 0) begin
      $display("** aes_block_cipher_core: PASSED **");
    end else begin
      $display("** aes_block_cipher_core: FAILED **");
    end
    $finish;
  end

endmodule
